[src/sitoa_pkg.sv]
// Shared constants and types for the signed integer to decimal text converter.
package sitoa_pkg;

	// Width of the value field on the input channel.
	localparam int VALUE_W = 32;
	// Number of low bits of the value that are converted, as two's complement.
	localparam int VALUE_BITS = 32;
	// Magnitude padded to whole nibbles; the converter takes four bits per cycle.
	localparam int PAD_BITS = ((VALUE_BITS + 3) / 4) * 4;
	localparam int STEPS = PAD_BITS / 4;
	localparam int STEP_BITS = $clog2(STEPS);
	// Decimal digits needed for any VALUE_BITS-bit unsigned magnitude.
	localparam int DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
	localparam int DIGIT_IDX_BITS = $clog2(DIGITS);
	localparam int BCD_BITS = DIGITS * 4;

	// Queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

	// Character codes.
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;
	localparam logic [7:0] ASCII_NINE = 8'h39;

	// One classified number: its sign and its unsigned magnitude.
	typedef struct packed {
		logic                  neg;
		logic [VALUE_BITS-1:0] mag;
	} job_t;

endpackage

[src/sitoa_if.sv]
// Valid/ready channel interfaces for the numbers in and the characters out.
interface sitoa_in_if
	import sitoa_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

interface sitoa_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last;

	modport source(output valid, output char_code, output last, input ready);
	modport sink(input valid, input char_code, input last, output ready);
endinterface

[src/sitoa_front.sv]
// Front part: accepts numbers, splits each into sign and magnitude.
module sitoa_front
	import sitoa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [VALUE_W-1:0] in_value,
	output logic               job_valid,
	input  logic               job_ready,
	output job_t               job
);

	logic                  valid_s1;
	job_t                  job_s1;
	logic [VALUE_BITS-1:0] raw;
	logic                  neg;

	// The stage takes a new number when empty or when its content moves on.
	assign in_ready = !valid_s1 || job_ready;
	assign job_valid = valid_s1;
	assign job = job_s1;

	// Sign and magnitude; the magnitude is unsigned so the most negative value fits.
	assign raw = in_value[VALUE_BITS-1:0];
	assign neg = raw[VALUE_BITS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			job_s1.neg <= neg;
			job_s1.mag <= neg ? VALUE_BITS'(~raw + 1'b1) : raw;
		end
	end

endmodule

[src/sitoa_queue.sv]
// Short queue that decouples the front from the back.
module sitoa_queue
	import sitoa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_data
);

	job_t                 entries_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wptr_q;
	logic [QPTR_BITS-1:0] rptr_q;
	logic [QCNT_BITS-1:0] cnt_q;
	logic                 push;
	logic                 pop;

	assign push_ready = cnt_q != QCNT_BITS'(QUEUE_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_data = entries_q[rptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wptr_q] <= push_data;
		end
	end

endmodule

[src/sitoa_back.sv]
// Back part: binary to BCD conversion and character by character output.
module sitoa_back
	import sitoa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_valid,
	output logic       job_ready,
	input  job_t       job,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       out_last
);

	// Converter registers.
	logic [PAD_BITS-1:0]  sh_q;
	logic [BCD_BITS-1:0]  bcd_q;
	logic                 neg_q;
	logic [STEP_BITS-1:0] cnt_q;
	logic                 busy_q;
	logic                 full_q;
	logic [BCD_BITS-1:0]  bcd_next;

	// Emitter registers.
	logic                      active_q;
	logic                      minus_q;
	logic [DIGIT_IDX_BITS-1:0] idx_q;
	logic [BCD_BITS-1:0]       digits_q;
	logic [DIGIT_IDX_BITS-1:0] top_idx;
	logic [3:0]                cur_digit;
	logic                      xfer;
	logic                      load;

	// One shift-add-3 step: adjust each digit of five or more, then shift a bit in.
	function automatic logic [BCD_BITS-1:0] dabble(input logic [BCD_BITS-1:0] b,
		input logic bit_in);
		logic [BCD_BITS-1:0] a;
		a = b;
		for (int d = 0; d < DIGITS; d++) begin
			if (a[d*4 +: 4] >= 4'd5) begin
				a[d*4 +: 4] = a[d*4 +: 4] + 4'd3;
			end
		end
		return {a[BCD_BITS-2:0], bit_in};
	endfunction

	// Four magnitude bits per cycle, most significant first.
	always_comb begin
		bcd_next = bcd_q;
		for (int b = 0; b < 4; b++) begin
			bcd_next = dabble(bcd_next, sh_q[PAD_BITS-1-b]);
		end
	end

	assign job_ready = !busy_q && !full_q;

	// Converter control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			full_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (job_valid && job_ready) begin
				busy_q <= 1'b1;
				cnt_q <= STEP_BITS'(STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					full_q <= 1'b1;
				end
			end else if (load) begin
				full_q <= 1'b0;
			end
		end
	end

	// Converter datapath.
	always_ff @(posedge clk) begin
		if (job_valid && job_ready) begin
			sh_q <= PAD_BITS'(job.mag);
			bcd_q <= '0;
			neg_q <= job.neg;
		end else if (busy_q) begin
			sh_q <= {sh_q[PAD_BITS-5:0], 4'b0000};
			bcd_q <= bcd_next;
		end
	end

	// Position of the leading nonzero digit; zero prints as one digit.
	always_comb begin
		top_idx = '0;
		for (int d = 0; d < DIGITS; d++) begin
			if (bcd_q[d*4 +: 4] != 4'd0) begin
				top_idx = DIGIT_IDX_BITS'(d);
			end
		end
	end

	// Current character from the emitter registers.
	assign cur_digit = digits_q[idx_q*4 +: 4];
	assign out_valid = active_q;
	assign out_char = minus_q ? ASCII_MINUS : ASCII_ZERO + {4'b0000, cur_digit};
	assign out_last = !minus_q && (idx_q == '0);
	assign xfer = out_valid && out_ready;
	assign load = full_q && (!active_q || (xfer && out_last));

	// Emitter control: sign first, then digits from the leading one down.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			minus_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			active_q <= 1'b1;
			minus_q <= neg_q;
			idx_q <= top_idx;
		end else if (xfer) begin
			if (minus_q) begin
				minus_q <= 1'b0;
			end else if (idx_q == '0) begin
				active_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			digits_q <= bcd_q;
		end
	end

endmodule

[src/signed_int_to_decimal_ascii.sv]
// A number passes the front stage, the queue, the converter and the emitter before its first character.
// Throughput: one character per cycle while the output is ready and a converted number waits;
// the converter takes four bits per cycle and works on the next number while one is emitted.
// Up to two classified numbers wait in the queue while the output stalls.
// Reset: arst_n low clears all control state at once; nothing is pending afterward.
// Top level: signed integer to decimal ASCII characters.
module signed_int_to_decimal_ascii
	import sitoa_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	sitoa_in_if.sink    number,
	sitoa_out_if.source text
);

	logic job_valid;
	logic job_ready;
	job_t job;
	logic q_valid;
	logic q_ready;
	job_t q_job;

	sitoa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (number.valid),
		.in_ready  (number.ready),
		.in_value  (number.value),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	sitoa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (job_valid),
		.push_ready (job_ready),
		.push_data  (job),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_job)
	);

	sitoa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job_ready (q_ready),
		.job       (q_job),
		.out_valid (text.valid),
		.out_ready (text.ready),
		.out_char  (text.char_code),
		.out_last  (text.last)
	);

endmodule

[src/sitoa_checker.sv]
// Port-level checks on the character output, bound to the top level.
module sitoa_checker
	import sitoa_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       out_last
);

	// A stalled character stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("stalled character withdrawn");

	// Every character is a minus sign or a decimal digit.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_char == ASCII_MINUS) ||
			((out_char >= ASCII_ZERO) && (out_char <= ASCII_NINE)))
		else $error("character outside the decimal alphabet");

	// A number always ends on a digit, never on its sign.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_char == ASCII_MINUS) |-> !out_last)
		else $error("minus sign flagged as last");

	// A transfer of a minus sign is not followed at once by a second minus sign.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && (out_char == ASCII_MINUS) |=>
			!out_valid || (out_char != ASCII_MINUS))
		else $error("two minus signs in a row");

endmodule

bind signed_int_to_decimal_ascii sitoa_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (text.valid),
	.out_ready (text.ready),
	.out_char  (text.char_code),
	.out_last  (text.last)
);
